// File: rtl/core/rws_pkg.sv
// ----------------------------------------------------------------------------
// rws_pkg
// Shared constants and types for the roulette wheel selector.
// ----------------------------------------------------------------------------
`default_nettype none

package rws_pkg;

    localparam int MAX_SLOTS = 64;
    localparam int MARK_W    = 32;
    localparam int DRAW_W    = 16;
    localparam int SLOT_W    = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int CFG_W     = 7;
    localparam int TOTAL_W   = MARK_W + SLOT_W;
    localparam int PROD_W    = TOTAL_W + DRAW_W;

    localparam int IN_DATA_W  = ((SLOT_W + MARK_W + DRAW_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((SLOT_W + MARK_W + 7) / 8) * 8;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_SUM   = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_PNT   = 7'b0001000,
        ST_SCAN  = 7'b0010000,
        ST_FETCH = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

// File: rtl/core/rws_ram.sv
// ----------------------------------------------------------------------------
// rws_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: rtl/core/roulette_wheel_selector.sv
// Load item: accepted while idle, no result. Select item: sums the marks of
// the N slots in use (N at most 64), multiplies by the draw, forms the point,
// scans until a running sum reaches it, else fetches slot 0; both passes share
// the mark RAM's single read port. One item is in work at a time; a finished
// result waits in the output register while the next item is taken. Synchronous
// active-low reset clears all marks (per-slot valid bits), the count to 64, the control.
// ----------------------------------------------------------------------------
// roulette_wheel_selector
// Fitness-proportionate selection over a RAM of stored marks.
// ----------------------------------------------------------------------------
`default_nettype none

module roulette_wheel_selector
    import rws_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write: candidate_count
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_W-1:0]      i_cfg_data,
    // input items
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // slot, mark, draw, zero pad
    input  wire logic                  i_s_tuser,   // opcode
    // result items
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // selected_slot, selected_mark, zero pad
    output logic                       o_m_tuser    // fell_through
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_count;
    logic [CNT_W-1:0]   r_eff_cnt, n_eff_cnt;
    logic [MAX_SLOTS-1:0] r_valid;
    logic [DRAW_W-1:0]  r_draw, n_draw;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [SLOT_W-1:0]  r_pend_idx, n_pend_idx;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [TOTAL_W-1:0] r_point, n_point;
    logic [TOTAL_W-1:0] r_sum, n_sum;
    logic [SLOT_W-1:0]  r_res_slot, n_res_slot;
    logic [MARK_W-1:0]  r_res_mark, n_res_mark;
    logic               r_res_fell, n_res_fell;
    logic               r_out_vld, n_out_vld;
    logic [SLOT_W-1:0]  r_out_slot, n_out_slot;
    logic [MARK_W-1:0]  r_out_mark, n_out_mark;
    logic               r_out_fell, n_out_fell;

    logic               in_acc;
    logic               in_op;
    logic [SLOT_W-1:0]  in_slot;
    logic [MARK_W-1:0]  in_mark;
    logic [DRAW_W-1:0]  in_draw;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [MARK_W-1:0]  ram_rdata;
    logic [MARK_W-1:0]  rd_mark;
    logic               issue;
    logic [TOTAL_W-1:0] sum_next;
    logic [PROD_W-1:0]  prod_rnd;

    assign in_op   = i_s_tuser;
    assign in_slot = i_s_tdata[SLOT_W-1:0];
    assign in_mark = i_s_tdata[SLOT_W+MARK_W-1:SLOT_W];
    assign in_draw = i_s_tdata[SLOT_W+MARK_W+DRAW_W-1:SLOT_W+MARK_W];

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign ram_we      = in_acc && (in_op == OP_LOAD);

    // slot never written since reset reads as zero
    assign rd_mark  = r_valid[r_pend_idx] ? ram_rdata : '0;
    assign sum_next = r_sum + TOTAL_W'(rd_mark);
    assign issue    = (r_idx < r_eff_cnt);
    assign prod_rnd = r_prod + PROD_W'({DRAW_W{1'b1}});

    assign ram_raddr = (r_state == ST_FETCH) ? '0 : r_idx[SLOT_W-1:0];

    rws_ram #(
        .WIDTH (MARK_W),
        .DEPTH (MAX_SLOTS)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (in_slot),
        .i_wdata (in_mark),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_eff_cnt  = r_eff_cnt;
        n_draw     = r_draw;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_idx = r_pend_idx;
        n_total    = r_total;
        n_prod     = r_prod;
        n_point    = r_point;
        n_sum      = r_sum;
        n_res_slot = r_res_slot;
        n_res_mark = r_res_mark;
        n_res_fell = r_res_fell;
        n_out_vld  = r_out_vld && !i_m_tready;
        n_out_slot = r_out_slot;
        n_out_mark = r_out_mark;
        n_out_fell = r_out_fell;

        case (r_state)
            ST_IDLE: begin
                if (in_acc && (in_op == OP_SELECT)) begin
                    n_draw    = in_draw;
                    n_eff_cnt = (CNT_W'(r_count) > CNT_W'(MAX_SLOTS)) ?
                                CNT_W'(MAX_SLOTS) : CNT_W'(r_count);
                    n_idx     = '0;
                    n_pend    = 1'b0;
                    n_total   = '0;
                    n_state   = ST_SUM;
                end
            end
            ST_SUM: begin
                if (r_pend) begin
                    n_total = r_total + TOTAL_W'(rd_mark);
                end
                n_pend     = issue;
                n_pend_idx = r_idx[SLOT_W-1:0];
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end else if (!r_pend) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod  = PROD_W'(r_total) * PROD_W'(r_draw);
                n_state = ST_PNT;
            end
            ST_PNT: begin
                // ceil(draw * total / 2^DRAW_W)
                n_point = prod_rnd[PROD_W-1:DRAW_W];
                n_idx   = '0;
                n_pend  = 1'b0;
                n_sum   = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (r_pend && (sum_next >= r_point)) begin
                    n_res_slot = r_pend_idx;
                    n_res_mark = rd_mark;
                    n_res_fell = 1'b0;
                    n_pend     = 1'b0;
                    n_state    = ST_DONE;
                end else begin
                    if (r_pend) begin
                        n_sum = sum_next;
                    end
                    n_pend     = issue;
                    n_pend_idx = r_idx[SLOT_W-1:0];
                    if (issue) begin
                        n_idx = r_idx + CNT_W'(1);
                    end else if (!r_pend) begin
                        n_state = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                // no sum reached the point: report slot 0
                if (!r_pend) begin
                    n_pend     = 1'b1;
                    n_pend_idx = '0;
                end else begin
                    n_res_slot = '0;
                    n_res_mark = rd_mark;
                    n_res_fell = 1'b1;
                    n_pend     = 1'b0;
                    n_state    = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    n_out_vld  = 1'b1;
                    n_out_slot = r_res_slot;
                    n_out_mark = r_res_mark;
                    n_out_fell = r_res_fell;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= CFG_W'(MAX_SLOTS);
            r_valid   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid && o_cfg_ready) begin
                r_count <= i_cfg_data;
            end
            if (ram_we) begin
                r_valid[in_slot] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_eff_cnt  <= n_eff_cnt;
        r_draw     <= n_draw;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_total    <= n_total;
        r_prod     <= n_prod;
        r_point    <= n_point;
        r_sum      <= n_sum;
        r_res_slot <= n_res_slot;
        r_res_mark <= n_res_mark;
        r_res_fell <= n_res_fell;
        r_out_slot <= n_out_slot;
        r_out_mark <= n_out_mark;
        r_out_fell <= n_out_fell;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = OUT_DATA_W'({r_out_mark, r_out_slot});
    assign o_m_tuser  = r_out_fell;

endmodule

`default_nettype wire

// File: rtl/core/rws_checker.sv
// ----------------------------------------------------------------------------
// rws_checker
// Port-level checks for the roulette wheel selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rws_checker
    import rws_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_s_tvalid,
    input wire logic                  o_s_tready,
    input wire logic                  i_s_tuser,
    input wire logic                  o_m_tvalid,
    input wire logic                  i_m_tready,
    input wire logic [OUT_DATA_W-1:0] o_m_tdata,
    input wire logic                  o_m_tuser
);

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // fell through always reports slot 0
    a_fell_slot0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata[SLOT_W-1:0] == '0))
        else $error("fell_through with nonzero slot");

    // a select item keeps the input closed for the next cycle
    a_select_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == OP_SELECT)) |=> !o_s_tready)
        else $error("input reopened right after a select");

    // a load item never raises a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && (i_s_tuser == OP_LOAD) && !o_m_tvalid)
        |=> !o_m_tvalid)
        else $error("result after a load item");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind roulette_wheel_selector rws_checker u_rws_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire

// File: verif/tb_roulette_wheel_selector.sv
// ----------------------------------------------------------------------------
// tb_roulette_wheel_selector
// Self-checking bench for the roulette wheel selector: loads and selects are
// driven on the input stream, each result is compared against a software
// copy of the mark table that reproduces the fixed-point selection.
// ----------------------------------------------------------------------------

module tb_roulette_wheel_selector;
    import rws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SETTLE_CYCLES = 200;     // longer than one full select
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int          PHASES        = 8;
    localparam int          PHASE_ITEMS   = 90;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [MARK_W-1:0] mark;
        logic              fell;
    } t_pick;

    // Keeps its own mark table and count, predicts every select.
    class selection_tracker;
        logic [MARK_W-1:0] marks [MAX_SLOTS];
        logic [CFG_W-1:0]  count;
        t_pick             picks_due [$];
        int                errors;

        function new();
            foreach (marks[k]) marks[k] = '0;
            count  = CFG_W'(MAX_SLOTS);
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        function void set_count(logic [CFG_W-1:0] value);
            count = value;
        endfunction

        function t_pick pick_slot(logic [DRAW_W-1:0] draw);
            int           n;
            logic [63:0]  total;
            logic [63:0]  point;
            logic [63:0]  run;
            t_pick        r;
            n     = (count > MAX_SLOTS) ? MAX_SLOTS : int'(count);
            total = '0;
            for (int k = 0; k < n; k++) total += 64'(marks[k]);
            // ceiling of draw * total / 2^DRAW_W
            point = (total * 64'(draw) + ((64'd1 << DRAW_W) - 64'd1)) >> DRAW_W;
            r.slot = '0;
            r.fell = 1'b1;
            run    = '0;
            for (int k = 0; k < n; k++) begin
                run += 64'(marks[k]);
                if (run >= point) begin
                    r.slot = SLOT_W'(k);
                    r.fell = 1'b0;
                    break;
                end
            end
            r.mark = marks[r.slot];
            return r;
        endfunction

        function void take_item(logic op, logic [SLOT_W-1:0] slot,
                                logic [MARK_W-1:0] mark, logic [DRAW_W-1:0] draw);
            if (op == OP_LOAD) marks[slot] = mark;
            else picks_due.insert(picks_due.size(), pick_slot(draw));
        endfunction

        function void match_result(logic [SLOT_W-1:0] slot, logic [MARK_W-1:0] mark,
                                   logic fell);
            t_pick want;
            if (picks_due.size() == 0) begin
                flag($sformatf("unexpected result: slot=%0d mark=%h fell=%0b",
                               slot, mark, fell));
            end else begin
                want = picks_due.pop_front();
                if (want.slot !== slot || want.mark !== mark || want.fell !== fell)
                    flag($sformatf({"result mismatch: expected slot=%0d mark=%h fell=%0b,",
                                    " got slot=%0d mark=%h fell=%0b"},
                                   want.slot, want.mark, want.fell, slot, mark, fell));
            end
        endfunction

        function int pending();
            return picks_due.size();
        endfunction
    endclass

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_W-1:0]       i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [IN_DATA_W-1:0]   i_s_tdata   = '0;
    logic                   i_s_tuser   = 1'b0;
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   o_m_tuser;

    selection_tracker sb;
    int          send_pct  = 0;
    int          stall_pct = 0;
    int          cur_count = MAX_SLOTS;
    int unsigned cycles    = 0;

    roulette_wheel_selector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_m_tready <= (stall_pct == 0) || ($urandom_range(0, 99) >= stall_pct);
    end

    // observe handshakes at the edge, values as the block saw them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.set_count(i_cfg_data);
            if (o_m_tvalid && i_m_tready)
                sb.match_result(o_m_tdata[SLOT_W-1:0], o_m_tdata[SLOT_W +: MARK_W],
                                o_m_tuser);
            if (i_s_tvalid && o_s_tready)
                sb.take_item(i_s_tuser, i_s_tdata[SLOT_W-1:0], i_s_tdata[SLOT_W +: MARK_W],
                             i_s_tdata[SLOT_W+MARK_W +: DRAW_W]);
        end
    end

    task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [MARK_W-1:0] mark,
                             logic [DRAW_W-1:0] draw);
        int                   gap;
        logic [IN_DATA_W-1:0] data;
        gap = 0;
        while (send_pct != 0 && $urandom_range(0, 99) < send_pct) gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        data = '0;
        data[SLOT_W-1:0]              = slot;
        data[SLOT_W +: MARK_W]        = mark;
        data[SLOT_W+MARK_W +: DRAW_W] = draw;
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= data;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    task automatic wait_results();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_count(logic [CFG_W-1:0] value);
        wait_results();
        // extra margin before the write
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        cur_count = (value > MAX_SLOTS) ? MAX_SLOTS : int'(value);
    endtask

    function automatic logic [MARK_W-1:0] random_mark();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return MARK_W'($urandom_range(0, 1000));
            default: return MARK_W'($urandom());
        endcase
    endfunction

    function automatic logic [DRAW_W-1:0] random_draw();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return DRAW_W'($urandom());
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] random_slot();
        // mostly hit the slots in use so loads move the outcome
        if (cur_count > 0 && $urandom_range(0, 3) != 0)
            return SLOT_W'($urandom_range(0, cur_count - 1));
        return SLOT_W'($urandom());
    endfunction

    task automatic random_phase(int items, bit hold_mid);
        int  n;
        int  loads;
        int  sels;
        bit  held;
        n    = 0;
        held = 1'b0;
        while (n < items) begin
            if ($urandom_range(0, 4) == 0) begin
                // noise: opcode and all fields random
                send_item(logic'($urandom_range(0, 1)), SLOT_W'($urandom()),
                          MARK_W'($urandom()), DRAW_W'($urandom()));
                n++;
            end else begin
                loads = $urandom_range(1, 6);
                sels  = $urandom_range(1, 4);
                repeat (loads)
                    send_item(OP_LOAD, random_slot(), random_mark(), DRAW_W'($urandom()));
                repeat (sels)
                    send_item(OP_SELECT, SLOT_W'($urandom()), MARK_W'($urandom()),
                              random_draw());
                n += loads + sels;
            end
            if (hold_mid && !held && n >= items / 2) begin
                wait_results();
                held = 1'b1;
            end
        end
    endtask

    initial begin
        logic [CFG_W-1:0] counts [PHASES];
        sb = new();
        counts = '{CFG_W'(64), CFG_W'(1), CFG_W'(0), CFG_W'(127), CFG_W'(2), CFG_W'(65),
                   CFG_W'($urandom_range(0, 127)), CFG_W'($urandom_range(1, 64))};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table: point is zero, slot 0 wins
        send_item(OP_SELECT, '0, '0, '0);
        send_item(OP_SELECT, '1, '1, '1);
        send_item(OP_LOAD, 6'd63, '1, '1);
        send_item(OP_LOAD, 6'd0, '1, '0);
        send_item(OP_SELECT, '0, '0, '0);
        send_item(OP_SELECT, '0, '0, '1);
        send_item(OP_SELECT, '0, '0, 16'h8000);
        send_item(OP_LOAD, 6'd31, 32'd1, '0);
        send_item(OP_LOAD, 6'd0, '0, '1);
        send_item(OP_SELECT, '0, '0, 16'd1);
        send_item(OP_SELECT, '0, '0, 16'h7FFF);
        send_item(OP_SELECT, '0, '0, 16'h8000);
        send_item(OP_SELECT, '1, '1, '1);
        send_item(OP_LOAD, 6'd63, '0, '0);
        send_item(OP_SELECT, '0, '0, '1);
        for (int k = 1; k < 6; k++)
            send_item(OP_LOAD, SLOT_W'(k), MARK_W'($urandom_range(1, 100)), '0);
        send_item(OP_SELECT, '0, '0, 16'd0);
        send_item(OP_SELECT, '0, '0, 16'h4000);
        send_item(OP_SELECT, '0, '0, 16'hC000);
        send_item(OP_SELECT, '0, '0, '1);

        for (int p = 0; p < PHASES; p++) begin
            write_count(counts[p]);
            case (p % 4)
                0: begin send_pct = 0;  stall_pct = 0;  end
                1: begin send_pct = 82; stall_pct = 0;  end
                2: begin send_pct = 0;  stall_pct = 82; end
                default: begin send_pct = 29; stall_pct = 29; end
            endcase
            random_phase(PHASE_ITEMS, p == 2);
        end

        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.flag($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
